>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/sbds_pkg.sv
// ----------------------------------------------------------------------------
// sbds_pkg
// Types and constants shared by the serial clock divider search block.
// ----------------------------------------------------------------------------
`default_nettype none

package sbds_pkg;

	localparam int unsigned RATE_W    = 32;
	localparam int unsigned PRESC_W   = 3;
	localparam int unsigned DIV_W     = 8;
	localparam int unsigned DIVISOR_W = DIV_W + 1;

	localparam logic [PRESC_W-1:0]   PRESCALE_LAST     = 3'd7;
	localparam logic [DIV_W-1:0]     DIVIDER_LAST      = 8'd255;
	localparam logic [DIV_W-1:0]     DIVIDER_FIRST     = 8'd0;
	localparam logic [DIVISOR_W-1:0] DIVIDER_OFFSET    = 9'd2;
	localparam logic [PRESC_W-1:0]   NO_MATCH_PRESCALE = 3'd7;
	localparam logic [DIV_W-1:0]     NO_MATCH_DIVIDER  = 8'd255;
	localparam logic [RATE_W-1:0]    DIFF_START        = 32'hFFFF_FFFF;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture a new request and reset the best candidate
		logic div_start; // start the division for the current divider
		logic eval;      // evaluate one prescaler for the current quotient
		logic next_d;    // advance to the next divider
		logic out_load;  // copy the best candidate into the result register
	} sbds_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
		logic p_last;
		logic d_last;
		logic exact;
	} sbds_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/sbds_div.sv
// ----------------------------------------------------------------------------
// sbds_div
// Restoring radix-2 divider: 32-bit dividend by a 9-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbds_div (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic [sbds_pkg::RATE_W-1:0]           dividend,
	input  wire logic [sbds_pkg::DIVISOR_W-1:0]        divisor,
	output logic                                       done,
	output logic [sbds_pkg::RATE_W-1:0]                quotient
);

	localparam int unsigned CNT_W = $clog2(sbds_pkg::RATE_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(sbds_pkg::RATE_W - 1);

	logic                              busy_q;
	logic                              done_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic [sbds_pkg::RATE_W-1:0]       quot_q;
	logic [sbds_pkg::DIVISOR_W-1:0]    rem_q;
	logic [sbds_pkg::DIVISOR_W-1:0]    divisor_q;
	logic [sbds_pkg::DIVISOR_W:0]      trial;
	logic [sbds_pkg::DIVISOR_W:0]      trial_sub;
	logic                              trial_ge;

	always_comb begin
		trial     = {rem_q, quot_q[sbds_pkg::RATE_W-1]};
		trial_sub = trial - {1'b0, divisor_q};
		trial_ge  = trial >= {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			// The partial remainder always stays below the divisor, so it fits.
			rem_q  <= trial_ge ? trial_sub[sbds_pkg::DIVISOR_W-1:0]
			                   : trial[sbds_pkg::DIVISOR_W-1:0];
			quot_q <= {quot_q[sbds_pkg::RATE_W-2:0], trial_ge};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

`default_nettype wire

>>> hw/rtl/sbds_datapath.sv
// ----------------------------------------------------------------------------
// sbds_datapath
// Request registers, divider and prescaler counters, best-candidate
// tracking, configuration register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbds_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [sbds_pkg::RATE_W-1:0]         cfg_data,
	input  wire logic [sbds_pkg::RATE_W-1:0]         target_rate_hz,
	input  wire logic                                keep_divider,
	input  wire logic [sbds_pkg::DIV_W-1:0]          current_divider,
	input  wire sbds_pkg::sbds_cmd_t                 cmd,
	output sbds_pkg::sbds_stat_t                     stat,
	output logic [sbds_pkg::PRESC_W-1:0]             prescale_index,
	output logic [sbds_pkg::DIV_W-1:0]               divider_value
);

	logic [sbds_pkg::RATE_W-1:0]    source_q;
	logic [sbds_pkg::RATE_W-1:0]    target_q;
	logic                           keep_q;
	logic [sbds_pkg::DIV_W-1:0]     d_q;
	logic [sbds_pkg::PRESC_W-1:0]   p_q;
	logic [sbds_pkg::RATE_W-1:0]    best_diff_q;
	logic [sbds_pkg::PRESC_W-1:0]   best_p_q;
	logic [sbds_pkg::DIV_W-1:0]     best_d_q;
	logic [sbds_pkg::PRESC_W-1:0]   out_p_q;
	logic [sbds_pkg::DIV_W-1:0]     out_d_q;

	logic [sbds_pkg::DIVISOR_W-1:0] divisor;
	logic [sbds_pkg::RATE_W-1:0]    quotient;
	logic                           div_done;
	logic [sbds_pkg::RATE_W-1:0]    rate;
	logic [sbds_pkg::RATE_W-1:0]    diff;
	logic                           better;

	assign divisor = {1'b0, d_q} + sbds_pkg::DIVIDER_OFFSET;

	sbds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (source_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// floor(floor(src / (d+2)) / 2^p) equals floor(src / (2^p * (d+2))).
	always_comb begin
		rate   = quotient >> p_q;
		diff   = target_q - rate;
		better = (target_q >= rate) && (diff < best_diff_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q <= '0;
		end else if (cfg_we) begin
			source_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			target_q    <= target_rate_hz;
			keep_q      <= keep_divider;
			d_q         <= keep_divider ? current_divider : sbds_pkg::DIVIDER_FIRST;
			best_d_q    <= keep_divider ? current_divider : sbds_pkg::NO_MATCH_DIVIDER;
			best_p_q    <= sbds_pkg::NO_MATCH_PRESCALE;
			best_diff_q <= sbds_pkg::DIFF_START;
		end
		if (cmd.div_start) begin
			p_q <= '0;
		end
		if (cmd.eval) begin
			p_q <= p_q + 1'b1;
			if (better) begin
				best_diff_q <= diff;
				best_p_q    <= p_q;
				best_d_q    <= d_q;
			end
		end
		if (cmd.next_d) begin
			d_q <= d_q + 1'b1;
		end
		if (cmd.out_load) begin
			out_p_q <= best_p_q;
			out_d_q <= best_d_q;
		end
	end

	always_comb begin
		stat.div_done = div_done;
		stat.p_last   = p_q == sbds_pkg::PRESCALE_LAST;
		stat.d_last   = keep_q || (d_q == sbds_pkg::DIVIDER_LAST);
		stat.exact    = best_diff_q == '0;
	end

	assign prescale_index = out_p_q;
	assign divider_value  = out_d_q;

endmodule

`default_nettype wire

>>> hw/rtl/sbds_ctrl.sv
// ----------------------------------------------------------------------------
// sbds_ctrl
// Search sequencer: walks the divider and prescaler loops and runs the
// input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module sbds_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire sbds_pkg::sbds_stat_t stat,
	output sbds_pkg::sbds_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   in_fire;
	logic   out_free;

	assign in_fire  = in_valid && in_ready_q;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:  cmd.load = in_fire;
			ST_START: cmd.div_start = 1'b1;
			ST_WAIT:  cmd = '0;
			ST_SCAN: begin
				cmd.eval   = !stat.exact;
				cmd.next_d = !stat.exact && stat.p_last && !stat.d_last;
			end
			ST_DONE:  cmd.out_load = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// A new result beat may replace the one leaving in the same cycle.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						in_ready_q <= 1'b0;
						state_q    <= ST_START;
					end
				end
				ST_START: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (stat.div_done) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// An exact match ends the search before the next candidate.
					if (stat.exact) begin
						state_q <= ST_DONE;
					end else if (stat.p_last) begin
						state_q <= stat.d_last ? ST_DONE : ST_START;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						in_ready_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> hw/rtl/spi_baud_divider_search_core.sv
// ----------------------------------------------------------------------------
// spi_baud_divider_search_core
// Picks a prescaler exponent and divider for a requested serial clock rate.
// ----------------------------------------------------------------------------
// Each request beat on s_* yields one result beat on m_*. The search tries
// dividers 0..255 in order, each with prescalers 0..7, and keeps the highest
// achieved rate source_clock_hz / (2^p * (d+2)) that does not exceed the
// request; an exact match ends the search. One bit-serial division per
// divider value sets the pace. A keep-divider search tries only
// current_divider, and an exact match returns earlier. One request is
// processed at a time; a finished result waits in the output register
// while the next request is taken. Write source_clock_hz on cfg_* only
// while no request is in progress; cfg_ready is always high.
`default_nettype none

module spi_baud_divider_search_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,  // source_clock_hz
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // [31:0] target_rate_hz, [39:32] current_divider
	input  wire logic        s_tuser,   // [0] keep_divider
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata    // [2:0] prescale_index, [10:3] divider_value, zero
);

	sbds_pkg::sbds_cmd_t  cmd;
	sbds_pkg::sbds_stat_t stat;
	logic [sbds_pkg::PRESC_W-1:0] prescale_index;
	logic [sbds_pkg::DIV_W-1:0]   divider_value;

	assign cfg_ready = 1'b1;

	sbds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sbds_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid),
		.cfg_data        (cfg_data),
		.target_rate_hz  (s_tdata[31:0]),
		.keep_divider    (s_tuser),
		.current_divider (s_tdata[39:32]),
		.cmd             (cmd),
		.stat            (stat),
		.prescale_index  (prescale_index),
		.divider_value   (divider_value)
	);

	assign m_tdata = {5'b0, divider_value, prescale_index};

endmodule

`default_nettype wire

>>> hw/rtl/sbds_checker.sv
// ----------------------------------------------------------------------------
// sbds_checker
// Port-level assertions for the divider search block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sbds_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	// A stalled result beat keeps its value.
	`SBDS_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

	// The padding above the divider field is always zero.
	`SBDS_ASSERT_IMP(a_out_pad, clk, arst_n, m_tvalid, m_tdata[15:11] == 5'b0, "result padding not zero")

	// Only one request is in flight: the input closes right after a beat.
	`SBDS_ASSERT_NXT(a_one_req, clk, arst_n, s_tvalid && s_tready, !s_tready, "input open during a search")

	// The search needs a full division, so no result appears in the cycle after a request.
	`SBDS_ASSERT_NXT(a_no_instant, clk, arst_n, s_tvalid && s_tready, !$rose(m_tvalid), "result raised right after a request")

endmodule

bind spi_baud_divider_search_core sbds_checker u_sbds_checker (.*);

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial clock prescaler and divider search.
// ----------------------------------------------------------------------------
// Requests go in through a queue that a clocked driver empties onto s_*. Each
// accepted request is scored right away by a local copy of the search, and
// every result beat on m_* is compared with the oldest score. The run walks
// through several source clock settings, the extremes among them, and
// several mixes of sender gaps and receiver stalls.

module tb_top;

	localparam int unsigned PRESCALE_COUNT  = 8;
	localparam int unsigned DIVIDER_COUNT   = 256;
	localparam int unsigned WATCHDOG_LIMIT  = 60000;
	localparam int unsigned DRAIN_CYCLES    = 64;
	localparam int unsigned MAX_REPORTED    = 10;
	localparam int unsigned GAP_PCT         = 56;
	localparam int unsigned BOTH_PCT        = 31;

	typedef struct packed {
		logic [31:0] target;
		logic        keep;
		logic [7:0]  cur_div;
	} baud_request_t;

	typedef struct packed {
		logic [2:0] prescale_index;
		logic [7:0] divider_value;
	} baud_setting_t;

	typedef struct packed {
		baud_request_t req;
		baud_setting_t setting;
	} baud_score_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;  // [31:0] target_rate_hz, [39:32] current_divider
	logic        s_tuser   = 1'b0; // [0] keep_divider
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;          // [2:0] prescale_index, [10:3] divider_value

	baud_request_t request_q[$];
	baud_score_t   baud_score_q[$];

	logic [31:0]   source_clock_hz = '0;
	int unsigned   requests_queued = 0;
	int unsigned   requests_taken  = 0;
	int unsigned   cfg_beats       = 0;
	int unsigned   mismatch_count  = 0;
	int unsigned   quiet_cycles    = 0;
	int unsigned   send_gap_pct    = 0;
	int unsigned   stall_pct       = 0;
	logic          s_taken         = 1'b0;

	baud_request_t next_req;
	baud_score_t   oldest;
	baud_setting_t got;

	spi_baud_divider_search_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] baud_rate_of(input logic [31:0] src, input int unsigned p,
			input int unsigned d);
		return src / ((32'd1 << p) * (d + 32'(sbds_pkg::DIVIDER_OFFSET)));
	endfunction

	// Highest achieved rate at or below the request; the first of equal
	// candidates stays, and an exact hit ends the walk.
	function automatic baud_setting_t pick_baud_setting(input logic [31:0] src,
			input baud_request_t req);
		logic [31:0]   best_gap;
		logic [31:0]   rate;
		int unsigned   d_lo;
		int unsigned   d_hi;
		int unsigned   d;
		int unsigned   p;
		baud_setting_t best;
		best_gap = sbds_pkg::DIFF_START;
		best.prescale_index = sbds_pkg::NO_MATCH_PRESCALE;
		best.divider_value = req.keep ? req.cur_div : sbds_pkg::NO_MATCH_DIVIDER;
		d_lo = req.keep ? 32'(req.cur_div) : 0;
		d_hi = req.keep ? 32'(req.cur_div) + 1 : DIVIDER_COUNT;
		for (d = d_lo; d < d_hi && best_gap != 0; d++) begin
			for (p = 0; p < PRESCALE_COUNT && best_gap != 0; p++) begin
				rate = baud_rate_of(src, p, d);
				if (req.target >= rate && req.target - rate < best_gap) begin
					best_gap = req.target - rate;
					best.prescale_index = 3'(p);
					best.divider_value = 8'(d);
				end
			end
		end
		return best;
	endfunction

	function automatic baud_request_t make_random_request(input logic [31:0] src);
		baud_request_t req;
		int unsigned   kind;
		kind = $urandom_range(0, 99);
		req.cur_div = 8'($urandom_range(0, 255));
		req.target = $urandom;
		req.keep = 1'b0;
		if (kind < 40) begin
			// Fixed divider: either at or just above one of its rates or anything at all.
			req.keep = 1'b1;
			if ($urandom_range(0, 1) == 1)
				req.target = baud_rate_of(src, $urandom_range(0, 7), req.cur_div)
					+ 32'($urandom_range(0, 2));
		end else if (kind < 70) begin
			// Near an achievable rate with a small divider; half of them exact.
			req.target = baud_rate_of(src, $urandom_range(0, 7), $urandom_range(0, 20));
			if ($urandom_range(0, 1) == 1)
				req.target = req.target + 32'($urandom_range(1, 1000));
		end else if (kind >= 85) begin
			req.target = $urandom_range(0, 20000);
		end
		return req;
	endfunction

	task automatic queue_request(input logic [31:0] target, input logic keep,
			input logic [7:0] cur_div);
		request_q.push_back('{target: target, keep: keep, cur_div: cur_div});
		requests_queued++;
	endtask

	task automatic wait_idle();
		while (requests_taken != requests_queued || baud_score_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_source_clock(input logic [31:0] value);
		int unsigned beats_seen;
		beats_seen = cfg_beats;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(negedge clk); while (cfg_beats == beats_seen);
		cfg_valid <= 1'b0;
	endtask

	// Each setting starts from an idle block: every result in, then the write.
	task automatic start_setting(input logic [31:0] src, input int unsigned gap_pct,
			input int unsigned stall);
		wait_idle();
		write_source_clock(src);
		send_gap_pct = gap_pct;
		stall_pct = stall;
	endtask

	task automatic queue_random(input logic [31:0] src, input int unsigned count);
		repeat (count) request_q.push_back(make_random_request(src));
		requests_queued += count;
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_taken) begin
				if (request_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					next_req = request_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {next_req.cur_div, next_req.target};
					s_tuser <= next_req.keep;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= $urandom_range(0, 99) >= stall_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			// The result beat is checked first: it belongs to an older request.
			if (m_tvalid && m_tready) begin
				got.prescale_index = m_tdata[2:0];
				got.divider_value = m_tdata[10:3];
				if (baud_score_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTED)
						$display("unexpected result beat: p=%0d d=%0d",
							got.prescale_index, got.divider_value);
				end else begin
					oldest = baud_score_q.pop_front();
					if (got.prescale_index != oldest.setting.prescale_index
							|| got.divider_value != oldest.setting.divider_value) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTED)
							$display("mismatch: target=%0d keep=%0b cur=%0d exp p=%0d d=%0d got p=%0d d=%0d",
								oldest.req.target, oldest.req.keep, oldest.req.cur_div,
								oldest.setting.prescale_index, oldest.setting.divider_value,
								got.prescale_index, got.divider_value);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				next_req.target = s_tdata[31:0];
				next_req.cur_div = s_tdata[39:32];
				next_req.keep = s_tuser;
				baud_score_q.push_back('{req: next_req,
					setting: pick_baud_setting(source_clock_hz, next_req)});
				requests_taken++;
			end
			if (cfg_valid && cfg_ready) begin
				source_clock_hz = cfg_data;
				cfg_beats++;
			end
			s_taken <= s_tvalid && s_tready;

			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	logic [31:0] src_hz;

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed requests against a 48 MHz source, no idling.
		start_setting(32'd48_000_000, 0, 0);
		queue_request(32'd0, 1'b0, 8'd0);              // nothing fits, full search
		queue_request(32'd0, 1'b1, 8'd0);              // nothing fits, fixed divider
		queue_request(32'd0, 1'b1, 8'd255);
		queue_request(32'hFFFF_FFFF, 1'b0, 8'd255);    // widest request
		queue_request(32'hFFFF_FFFF, 1'b1, 8'd255);
		queue_request(32'd24_000_000, 1'b0, 8'd0);     // exact on the first candidate
		queue_request(32'd1_000_000, 1'b0, 8'd17);     // exact on the second divider
		queue_request(32'd1000, 1'b1, 8'd0);
		queue_request(32'd12_000_000, 1'b1, 8'd0);
		queue_request(32'd1459, 1'b0, 8'd0);           // at the slowest rate
		queue_request(32'd1458, 1'b0, 8'd0);           // just below the slowest rate
		queue_request(32'h8000_0000, 1'b1, 8'd128);
		queue_request(32'h7FFF_FFFF, 1'b1, 8'd127);
		queue_request(32'd500_000, 1'b1, 8'h55);
		queue_request(32'hAAAA_AAAA, 1'b1, 8'hAA);
		queue_request(32'd1_500_001, 1'b0, 8'd0);      // several equal rates, first kept

		// A stopped source clock: every rate is zero and always fits.
		start_setting(32'd0, GAP_PCT, 0);
		queue_request(32'd0, 1'b0, 8'd0);
		queue_request(32'd12345, 1'b1, 8'd77);
		queue_random(32'd0, 6);

		start_setting(32'hFFFF_FFFF, 0, GAP_PCT);
		queue_random(32'hFFFF_FFFF, 20);

		start_setting(32'd100_000_000, BOTH_PCT, BOTH_PCT);
		queue_random(32'd100_000_000, 20);

		src_hz = $urandom;
		start_setting(src_hz, GAP_PCT, 0);
		queue_random(src_hz, 20);

		start_setting(32'd1, 0, 0);
		queue_random(32'd1, 6);

		src_hz = $urandom_range(1000, 50_000_000);
		start_setting(src_hz, BOTH_PCT, BOTH_PCT);
		queue_random(src_hz, 20);

		start_setting(32'd24_000_000, 0, GAP_PCT);
		queue_random(32'd24_000_000, 12);

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && baud_score_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/sbds_pkg.sv
hw/rtl/sbds_div.sv
hw/rtl/sbds_datapath.sv
hw/rtl/sbds_ctrl.sv
hw/rtl/spi_baud_divider_search_core.sv
hw/rtl/sbds_checker.sv
dv/tb_top.sv
